FILE: design/mftep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mftep_pkg
// Shared types and constants for the MIDI file track event parser.
// ----------------------------------------------------------------------------
package mftep_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 7;
    localparam int VLQ_W   = 28;
    localparam int WAIT_W  = 36;
    localparam int MSPT_W  = 8;
    localparam int CHAN_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNEL = 1'd1;

    // Configuration reset values
    localparam logic [MSPT_W-1:0] MSPT_RESET = 8'd8;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd0;

    // Status codes: channel message kinds (high nibble), system statuses and the end-of-track meta type
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;
    localparam logic [BYTE_W-1:0] ST_SYSEX     = 8'hF0;
    localparam logic [BYTE_W-1:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [BYTE_W-1:0] ST_META      = 8'hFF;
    localparam logic [BYTE_W-1:0] META_END     = 8'h2F;

    // Parse phase
    typedef enum logic [2:0] {
        PH_DELTA    = 3'd0,
        PH_STATUS   = 3'd1,
        PH_DATA1    = 3'd2,
        PH_DATA2    = 3'd3,
        PH_METATYPE = 3'd4,
        PH_LENGTH   = 3'd5,
        PH_SKIP     = 3'd6
    } t_phase;

    // One result item
    typedef struct packed {
        logic [WAIT_W-1:0] wait_ms;
        logic              send_message;
        logic [BYTE_W-1:0] msg_status;
        logic [DATA_W-1:0] msg_data1;
        logic [DATA_W-1:0] msg_data2;
        logic              end_of_track;
    } t_result;

endpackage : mftep_pkg
`default_nettype wire

FILE: design/mftep_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mftep_byte_if
// Track byte channel: one track byte per item with a last-byte marker.
// ----------------------------------------------------------------------------
interface mftep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] track_byte;
    logic       last_in_track;

    modport source (output valid, output track_byte, output last_in_track, input ready);
    modport sink   (input valid, input track_byte, input last_in_track, output ready);
endinterface : mftep_byte_if
`default_nettype wire

FILE: design/mftep_event_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mftep_event_if
// Event channel: one completed track event per item.
// ----------------------------------------------------------------------------
interface mftep_event_if;
    logic        valid;
    logic        ready;
    logic [35:0] wait_ms;
    logic        send_message;
    logic [7:0]  msg_status;
    logic [6:0]  msg_data1;
    logic [6:0]  msg_data2;
    logic        end_of_track;

    modport source (output valid, output wait_ms, output send_message, output msg_status,
                    output msg_data1, output msg_data2, output end_of_track, input ready);
    modport sink   (input valid, input wait_ms, input send_message, input msg_status,
                    input msg_data1, input msg_data2, input end_of_track, output ready);
endinterface : mftep_event_if
`default_nettype wire

FILE: design/midi_file_track_event_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_file_track_event_parser_core
// Parses the body of a MIDI file track chunk, one byte per item, into events.
// ----------------------------------------------------------------------------
// Takes one track byte per clock cycle while input ready is high; an event's
// last byte has its result registered in the output stage. Each byte only
// advances a small parse state; the wait (delta ticks times ms_per_tick, a
// 28x8 product) is formed as the result register or skid is loaded. A
// two-entry output stage (result register plus skid) lets the parser keep
// taking bytes while one event waits; input ready drops only when both
// entries are full. Note off/on, poly key pressure and control change give a
// message with the channel from out_channel; other events give a wait only.
// last_in_track returns the parse state to its reset state after that byte.
// ----------------------------------------------------------------------------
module midi_file_track_event_parser_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [mftep_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [mftep_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mftep_byte_if.sink                   i_track,
    mftep_event_if.source                o_event
);
    import mftep_pkg::*;

    // Configuration
    logic [MSPT_W-1:0] r_ms_per_tick;
    logic [CHAN_W-1:0] r_out_channel;

    // Parse state
    t_phase            r_phase,   n_phase;
    logic [VLQ_W-1:0]  r_delta,   n_delta;
    logic [BYTE_W-1:0] r_run,     n_run;
    logic [DATA_W-1:0] r_first,   n_first;
    logic [VLQ_W-1:0]  r_skip,    n_skip;
    logic              r_meta_end, n_meta_end;
    logic [1:0]        r_vlq,     n_vlq;

    // Output stage
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic              w_accept;
    logic              w_pop;
    logic              w_done;
    logic              w_send;
    logic [DATA_W-1:0] w_d2;
    logic [VLQ_W-1:0]  w_len;
    logic [BYTE_W-1:0] w_b;
    logic              w_run_one_data;
    t_result           w_res;

    assign w_b      = i_track.track_byte;
    assign w_accept = i_track.valid && i_track.ready;
    assign w_pop    = r_out_valid && o_event.ready;
    assign i_track.ready = !r_skid_valid;

    assign w_run_one_data = (r_run[7:4] == KIND_PROGRAM) || (r_run[7:4] == KIND_PRESSURE);
    assign w_len          = {r_skip[VLQ_W-8:0], w_b[6:0]};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_per_tick <= MSPT_RESET;
            r_out_channel <= CHAN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MS_PER_TICK: r_ms_per_tick <= i_cfg_data;
                CFG_OUT_CHANNEL: r_out_channel <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Parse step for one byte
    always_comb begin
        n_phase    = r_phase;
        n_delta    = r_delta;
        n_run      = r_run;
        n_first    = r_first;
        n_skip     = r_skip;
        n_meta_end = r_meta_end;
        n_vlq      = r_vlq;
        w_done     = 1'b0;
        w_send     = 1'b0;
        w_d2       = w_b[6:0];

        unique case (r_phase)
            PH_STATUS: begin
                if (!w_b[7]) begin
                    // running status: this byte is the first data byte
                    if (r_run[7] && (r_run[7:4] != 4'hF)) begin
                        if (w_run_one_data) begin
                            w_done = 1'b1;
                        end else begin
                            n_first = w_b[6:0];
                            n_phase = PH_DATA2;
                        end
                    end else begin
                        w_done = 1'b1;
                    end
                end else if (w_b[7:4] != 4'hF) begin
                    n_run   = w_b;
                    n_phase = PH_DATA1;
                end else if (w_b == ST_META) begin
                    n_run   = '0;
                    n_phase = PH_METATYPE;
                end else if (w_b == ST_SYSEX || w_b == ST_SYSEX_ESC) begin
                    n_run      = '0;
                    n_meta_end = 1'b0;
                    n_skip     = '0;
                    n_vlq      = '0;
                    n_phase    = PH_LENGTH;
                end else begin
                    // other system status ends the event with no data
                    n_run  = '0;
                    w_done = 1'b1;
                end
            end
            PH_DATA1: begin
                if (w_run_one_data) begin
                    w_done = 1'b1;
                end else begin
                    n_first = w_b[6:0];
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA2: begin
                w_done = 1'b1;
                w_send = (r_run[7:6] == 2'b10);
            end
            PH_METATYPE: begin
                n_meta_end = (w_b == META_END);
                n_skip     = '0;
                n_vlq      = '0;
                n_phase    = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_skip = w_len;
                if (w_b[7] && (r_vlq != 2'd3)) begin
                    n_vlq = r_vlq + 2'd1;
                end else begin
                    n_vlq = '0;
                    if (w_len == '0) begin
                        w_done = 1'b1;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - VLQ_W'(1);
                if (r_skip == VLQ_W'(1)) begin
                    w_done = 1'b1;
                end
            end
            default: begin
                // delta time, one to four bytes
                n_delta = {r_delta[VLQ_W-8:0], w_b[6:0]};
                if (w_b[7] && (r_vlq != 2'd3)) begin
                    n_vlq   = r_vlq + 2'd1;
                    n_phase = PH_DELTA;
                end else begin
                    n_vlq   = '0;
                    n_phase = PH_STATUS;
                end
            end
        endcase

        // event complete: clear per-event state
        if (w_done) begin
            n_phase    = PH_DELTA;
            n_delta    = '0;
            n_skip     = '0;
            n_meta_end = 1'b0;
            n_vlq      = '0;
        end

        // final byte of the track: back to reset state
        if (i_track.last_in_track) begin
            n_phase    = PH_DELTA;
            n_delta    = '0;
            n_run      = '0;
            n_first    = '0;
            n_skip     = '0;
            n_meta_end = 1'b0;
            n_vlq      = '0;
        end
    end

    // Result item
    always_comb begin
        w_res.wait_ms      = {8'd0, r_delta} * {28'd0, r_ms_per_tick};
        w_res.send_message = w_send;
        w_res.msg_status   = w_send ? {r_run[7:4], r_out_channel} : '0;
        w_res.msg_data1    = w_send ? r_first : '0;
        w_res.msg_data2    = w_send ? w_d2 : '0;
        w_res.end_of_track = r_meta_end;
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DELTA;
            r_delta    <= '0;
            r_run      <= '0;
            r_first    <= '0;
            r_skip     <= '0;
            r_meta_end <= 1'b0;
            r_vlq      <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_delta    <= n_delta;
            r_run      <= n_run;
            r_first    <= n_first;
            r_skip     <= n_skip;
            r_meta_end <= n_meta_end;
            r_vlq      <= n_vlq;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept && w_done) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_accept && w_done) begin
            if (!r_out_valid || w_pop) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_event.valid        = r_out_valid;
    assign o_event.wait_ms      = r_out.wait_ms;
    assign o_event.send_message = r_out.send_message;
    assign o_event.msg_status   = r_out.msg_status;
    assign o_event.msg_data1    = r_out.msg_data1;
    assign o_event.msg_data2    = r_out.msg_data2;
    assign o_event.end_of_track = r_out.end_of_track;

    // Assertions
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register empty");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_track.last_in_track) |=> (r_phase == PH_DELTA && r_run == '0))
        else $error("parse state not cleared after last track byte");

    a_eot_no_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.end_of_track) |-> !o_event.send_message)
        else $error("end of track event carries a message");

    a_msg_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.send_message) |->
            (o_event.msg_status[7:6] == 2'b10 && o_event.msg_status[3:0] == r_out_channel))
        else $error("message status outside sent kinds or wrong channel");

endmodule : midi_file_track_event_parser_core
`default_nettype wire

FILE: test/mftep_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftep_event_checker
// Watches the track byte and event channels of the MIDI track event parser,
// predicts each event from the accepted track bytes and the register writes,
// and compares every emitted event field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mftep_event_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [mftep_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [mftep_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mftep_byte_if                           i_track,
    mftep_event_if                          i_event,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_events_checked
);
    import mftep_pkg::*;

    // high nibble of system statuses (sysex, meta and the rest)
    localparam logic [3:0] KIND_SYSTEM = 4'hF;

    // register mirror
    logic [MSPT_W-1:0] tick_ms;
    logic [CHAN_W-1:0] chan;

    // parser mirror
    t_phase            parse_ph;
    logic [VLQ_W-1:0]  delta_ticks;
    logic [BYTE_W-1:0] run_status;
    logic [DATA_W-1:0] data1_hold;
    logic [VLQ_W-1:0]  bytes_left;
    logic              end_flag;
    logic [1:0]        vlq_cnt;

    t_result predicted_events[$];
    int      fails = 0;
    int      events_seen = 0;

    assign o_fail_count     = fails;
    assign o_events_checked = events_seen;

    function automatic void clear_parse();
        parse_ph    = PH_DELTA;
        delta_ticks = '0;
        run_status  = '0;
        data1_hold  = '0;
        bytes_left  = '0;
        end_flag    = 1'b0;
        vlq_cnt     = '0;
    endfunction

    // Close the current event; running status survives into the next one
    function automatic t_result close_event(input logic send, input logic [DATA_W-1:0] d2);
        t_result r;
        r = '0;
        r.wait_ms = {{(WAIT_W-VLQ_W){1'b0}}, delta_ticks}
                  * {{(WAIT_W-MSPT_W){1'b0}}, tick_ms};
        r.send_message = send;
        if (send) begin
            r.msg_status = {run_status[7:4], chan};
            r.msg_data1  = data1_hold;
            r.msg_data2  = d2;
        end
        r.end_of_track = end_flag;
        parse_ph    = PH_DELTA;
        delta_ticks = '0;
        bytes_left  = '0;
        end_flag    = 1'b0;
        vlq_cnt     = '0;
        return r;
    endfunction

    // First data byte: program change and channel pressure end the event here
    function automatic logic take_data1(input logic [BYTE_W-1:0] b, output t_result r);
        r = '0;
        if (run_status[7:4] == KIND_PROGRAM || run_status[7:4] == KIND_PRESSURE) begin
            r = close_event(1'b0, '0);
            return 1'b1;
        end
        data1_hold = b[DATA_W-1:0];
        parse_ph   = PH_DATA2;
        return 1'b0;
    endfunction

    // Advance the parser mirror by one track byte; returns 1 when an event ends
    function automatic logic parse_track_byte(input logic [BYTE_W-1:0] b, input logic last,
                                              output t_result r);
        logic got;
        got = 1'b0;
        r   = '0;
        case (parse_ph)
            PH_STATUS: begin
                if (!b[7]) begin
                    // data byte where a status is due
                    if (run_status[7] && run_status[7:4] != KIND_SYSTEM) begin
                        got = take_data1(b, r);
                    end else begin
                        r   = close_event(1'b0, '0);
                        got = 1'b1;
                    end
                end else if (b[7:4] != KIND_SYSTEM) begin
                    run_status = b;
                    parse_ph   = PH_DATA1;
                end else if (b == ST_META) begin
                    run_status = '0;
                    parse_ph   = PH_METATYPE;
                end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                    run_status = '0;
                    end_flag   = 1'b0;
                    bytes_left = '0;
                    vlq_cnt    = '0;
                    parse_ph   = PH_LENGTH;
                end else begin
                    // other system status: event ends with no data
                    run_status = '0;
                    r   = close_event(1'b0, '0);
                    got = 1'b1;
                end
            end
            PH_DATA1: got = take_data1(b, r);
            PH_DATA2: begin
                // only 0x8n..0xBn give a message
                r   = close_event(run_status[7:6] == 2'b10, b[DATA_W-1:0]);
                got = 1'b1;
            end
            PH_METATYPE: begin
                end_flag   = (b == META_END);
                bytes_left = '0;
                vlq_cnt    = '0;
                parse_ph   = PH_LENGTH;
            end
            PH_LENGTH: begin
                bytes_left = {bytes_left[VLQ_W-8:0], b[6:0]};
                if (b[7] && vlq_cnt != 2'd3) begin
                    vlq_cnt = vlq_cnt + 2'd1;
                end else begin
                    vlq_cnt = '0;
                    if (bytes_left == '0) begin
                        r   = close_event(1'b0, '0);
                        got = 1'b1;
                    end else begin
                        parse_ph = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    r   = close_event(1'b0, '0);
                    got = 1'b1;
                end
            end
            default: begin
                // delta time; a fourth byte ends it whatever its top bit
                delta_ticks = {delta_ticks[VLQ_W-8:0], b[6:0]};
                if (b[7] && vlq_cnt != 2'd3) begin
                    vlq_cnt = vlq_cnt + 2'd1;
                end else begin
                    vlq_cnt  = '0;
                    parse_ph = PH_STATUS;
                end
            end
        endcase
        // last byte of a track: back to reset, registers kept
        if (last) clear_parse();
        return got;
    endfunction

    function automatic void check_field(input string name, input logic [WAIT_W-1:0] want,
                                        input logic [WAIT_W-1:0] seen);
        if (seen !== want) begin
            fails++;
            $display("%0t ns: event %0d %s mismatch, expected %0h actual %0h",
                     $time, events_seen, name, want, seen);
        end
    endfunction

    // Predict on accepted bytes, compare on accepted events
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result seen;
        logic    got;
        if (!i_rst_n) begin
            tick_ms = MSPT_RESET;
            chan    = CHAN_RESET;
            clear_parse();
            predicted_events.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MS_PER_TICK) tick_ms = i_cfg_data[MSPT_W-1:0];
                else if (i_cfg_idx == CFG_OUT_CHANNEL) chan = i_cfg_data[CHAN_W-1:0];
            end
            if (i_track.valid && i_track.ready) begin
                got = parse_track_byte(i_track.track_byte, i_track.last_in_track, want);
                if (got) predicted_events.push_back(want);
            end
            if (i_event.valid && i_event.ready) begin
                seen.wait_ms      = i_event.wait_ms;
                seen.send_message = i_event.send_message;
                seen.msg_status   = i_event.msg_status;
                seen.msg_data1    = i_event.msg_data1;
                seen.msg_data2    = i_event.msg_data2;
                seen.end_of_track = i_event.end_of_track;
                events_seen++;
                if (predicted_events.size() == 0) begin
                    fails++;
                    $display("%0t ns: event %0d, expected none, actual wait %0h msg %0b %0h %0h %0h end %0b",
                             $time, events_seen, seen.wait_ms, seen.send_message,
                             seen.msg_status, seen.msg_data1, seen.msg_data2,
                             seen.end_of_track);
                end else begin
                    want = predicted_events.pop_front();
                    check_field("wait_ms", want.wait_ms, seen.wait_ms);
                    check_field("send_message", want.send_message, seen.send_message);
                    check_field("msg_status", want.msg_status, seen.msg_status);
                    check_field("msg_data1", want.msg_data1, seen.msg_data1);
                    check_field("msg_data2", want.msg_data2, seen.msg_data2);
                    check_field("end_of_track", want.end_of_track, seen.end_of_track);
                end
            end
            o_pending <= predicted_events.size();
        end
    end

endmodule : mftep_event_checker

FILE: test/midi_file_track_event_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_file_track_event_parser_core_tb
// Drives whole MIDI tracks into the parser: a directed track over every event
// kind and corner case, then random tracks under several register settings
// and idle/stall mixes. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module midi_file_track_event_parser_core_tb;
    import mftep_pkg::*;

    // channel message kinds not named in the package
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_POLY_KEY = 4'hA;
    localparam logic [3:0] KIND_CONTROL  = 4'hB;
    localparam logic [3:0] KIND_PITCH    = 4'hE;
    // range of the other system statuses
    localparam logic [BYTE_W-1:0] ST_SYS_FIRST = 8'hF1;
    localparam logic [BYTE_W-1:0] ST_SYS_LAST  = 8'hFE;

    localparam int PHASE_BYTES  = 425;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int idle_pct;
    int stall_pct;
    int fail_count;
    int pending;
    int events_checked;
    int bytes_sent;
    int tracks_sent;
    int idle_mix[4]  = '{0, 82, 0, 35};
    int stall_mix[4] = '{0, 0, 82, 35};

    logic [BYTE_W-1:0] track_bytes[$];
    logic [BYTE_W-1:0] gen_status;

    mftep_byte_if  track_ch ();
    mftep_event_if event_ch ();

    midi_file_track_event_parser_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_track    (track_ch),
        .o_event    (event_ch)
    );

    mftep_event_checker event_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_track          (track_ch),
        .i_event          (event_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_events_checked (events_checked)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk) begin
        event_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // One byte: optional idle gap, then hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            track_ch.valid <= 1'b0;
            @(posedge clk);
        end
        track_ch.valid         <= 1'b1;
        track_ch.track_byte    <= b;
        track_ch.last_in_track <= last;
        @(posedge clk);
        while (!track_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_track();
        int k;
        for (k = 0; k < track_bytes.size(); k++) begin
            send_byte(track_bytes[k], k == track_bytes.size() - 1);
        end
        tracks_sent++;
    endtask

    // Idle the input, wait out every predicted event and the output stage
    task automatic drain();
        track_ch.valid         <= 1'b0;
        track_ch.last_in_track <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [MSPT_W-1:0] mspt, input logic [CHAN_W-1:0] chan);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MS_PER_TICK;
        cfg_data <= mspt;
        @(posedge clk);
        // junk in the unused upper bits
        cfg_idx  <= CFG_OUT_CHANNEL;
        cfg_data <= {(CFG_DATA_W-CHAN_W)'($urandom), chan};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // big-endian 7-bit groups, continuation bit on all but the last
    task automatic push_vlq(input logic [31:0] val, input int n);
        int k;
        for (k = n - 1; k >= 0; k--) begin
            track_bytes.push_back({k != 0, val[7*k +: 7]});
        end
    endtask

    task automatic push_delta();
        int          n;
        int unsigned sel;
        logic [7:0]  tail;
        sel = $urandom_range(9);
        n   = (sel < 6) ? 1 : (sel < 8) ? 2 : (sel < 9) ? 3 : 4;
        push_vlq($urandom, n);
        // fourth byte ends the delta either way
        if (n == 4) begin
            tail    = track_bytes.pop_back();
            tail[7] = 1'($urandom);
            track_bytes.push_back(tail);
        end
    endtask

    // mostly clean data, sometimes with bit 7 set
    function automatic logic [BYTE_W-1:0] data_byte();
        return ($urandom_range(9) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)};
    endfunction

    // length field plus that many bytes of any value
    task automatic push_body();
        int len;
        len = $urandom_range(0, 5);
        push_vlq(len, ($urandom_range(7) == 0) ? $urandom_range(2, 4) : 1);
        repeat (len) track_bytes.push_back(8'($urandom));
    endtask

    task automatic add_event();
        int unsigned       sel;
        logic [BYTE_W-1:0] st;
        push_delta();
        sel = $urandom_range(99);
        if (sel < 45) begin
            st = {4'(KIND_NOTE_OFF + $urandom_range(3)), 4'($urandom)};
            gen_status = st;
            track_bytes.push_back(st);
            track_bytes.push_back(data_byte());
            track_bytes.push_back(data_byte());
        end else if (sel < 58) begin
            // running status if one is held, else a bare data byte
            track_bytes.push_back({1'b0, 7'($urandom)});
            if (gen_status != '0 && gen_status[7:4] != KIND_PROGRAM
                    && gen_status[7:4] != KIND_PRESSURE) begin
                track_bytes.push_back(data_byte());
            end
        end else if (sel < 66) begin
            st = {(sel[0] ? KIND_PROGRAM : KIND_PRESSURE), 4'($urandom)};
            gen_status = st;
            track_bytes.push_back(st);
            track_bytes.push_back(data_byte());
        end else if (sel < 72) begin
            st = {KIND_PITCH, 4'($urandom)};
            gen_status = st;
            track_bytes.push_back(st);
            track_bytes.push_back(data_byte());
            track_bytes.push_back(data_byte());
        end else if (sel < 78) begin
            track_bytes.push_back($urandom_range(1) ? ST_SYSEX : ST_SYSEX_ESC);
            push_body();
            gen_status = '0;
        end else if (sel < 88) begin
            track_bytes.push_back(ST_META);
            track_bytes.push_back(($urandom_range(4) == 0) ? META_END : 8'($urandom));
            push_body();
            gen_status = '0;
        end else if (sel < 94) begin
            st = 8'($urandom_range(ST_SYS_FIRST, ST_SYS_LAST));
            if (st == ST_SYSEX_ESC) st = ST_SYS_FIRST;
            track_bytes.push_back(st);
            gen_status = '0;
        end else begin
            // noise
            repeat ($urandom_range(1, 3)) track_bytes.push_back(8'($urandom));
            gen_status = '0;
        end
    endtask

    // Random track: ends on end-of-track mostly, else loses up to two end bytes
    task automatic build_track();
        int n_ev;
        track_bytes.delete();
        gen_status = '0;
        n_ev = $urandom_range(1, 30);
        repeat (n_ev) add_event();
        if ($urandom_range(9) < 7) begin
            push_delta();
            track_bytes.push_back(ST_META);
            track_bytes.push_back(META_END);
            track_bytes.push_back(8'h00);
        end else begin
            repeat ($urandom_range(0, 2)) begin
                if (track_bytes.size() > 1) void'(track_bytes.pop_back());
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        int phase_start;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= CFG_MS_PER_TICK;
        cfg_data               <= '0;
        track_ch.valid         <= 1'b0;
        track_ch.track_byte    <= '0;
        track_ch.last_in_track <= 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        bytes_sent  = 0;
        tracks_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed track under reset register values
        track_bytes = '{
            8'hFF, 8'hFF, 8'hFF, 8'hFF, {KIND_NOTE_ON, 4'h0}, 8'h7F, 8'h80,
            8'h00, 8'h3C, 8'h00,
            8'h81, 8'h00, {KIND_NOTE_OFF, 4'h3}, 8'h3C, 8'h40,
            8'h00, {KIND_POLY_KEY, 4'h5}, 8'h01, 8'h02,
            8'h00, {KIND_CONTROL, 4'hF}, 8'h07, 8'h64,
            8'h00, {KIND_PROGRAM, 4'h2}, 8'h05,
            8'h00, {KIND_PRESSURE, 4'h9}, 8'h20,
            8'h00, {KIND_PITCH, 4'h1}, 8'h00, 8'h40,
            8'h00, ST_SYSEX, 8'h80, 8'h80, 8'h80, 8'h81, 8'h55,
            8'h00, 8'h33,
            8'h00, ST_SYSEX_ESC, 8'h00,
            8'h00, ST_META, 8'h01, 8'h01, 8'h41,
            8'h00, ST_SYS_FIRST,
            8'h00, ST_META, META_END, 8'h00
        };
        send_track();
        // track cut short inside a note
        track_bytes = '{8'h05, {KIND_NOTE_ON, 4'h0}, 8'h3C};
        send_track();
        drain();

        // Random tracks, one register setting and idle mix per phase
        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            case (ph)
                0: set_config('1, '1);
                1: set_config('0, '0);
                default: set_config(8'($urandom_range(1, 254)), 4'($urandom));
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_track();
                send_track();
            end
            drain();
        end

        $display("Sent %0d track bytes in %0d tracks: reset values plus four register settings,",
                 bytes_sent, tracks_sent);
        $display("four idle/stall mixes; %0d events compared, %0d errors, %0d still predicted.",
                 events_checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule : midi_file_track_event_parser_core_tb

FILE: files.f
design/mftep_pkg.sv
design/mftep_byte_if.sv
design/mftep_event_if.sv
design/midi_file_track_event_parser_core.sv
test/mftep_event_checker.sv
test/midi_file_track_event_parser_core_tb.sv
